// ===== rtl/core/first_fit_free_list_allocator_macros.svh =====
// assertion macros for the first-fit allocator
// used by ffa_ctrl and ffa_dp, no other dependencies
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define FFA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/ffa_pkg.sv =====
// shared types and constants of the first-fit allocator
// no dependencies
package ffa_pkg;

	localparam int REQ_W   = 1;
	localparam int BYTES_W = 24;
	localparam int ADDR_W  = 32;
	localparam int HU_W    = 17;
	localparam int CIDX_W  = 2;

	localparam logic [CIDX_W-1:0] CFG_HEAP_ACTIVE = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_HEAP_UNITS  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_ARENA_BASE  = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_FCHK, S_RSTART, S_RTEST, S_RBP, S_RNX, S_RP,
		S_ASTART, S_ANEXT, S_ATEST, S_ASPLIT, S_GROW, S_AFAIL, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_FREE_CHK, OP_REL_START, OP_REL_TEST, OP_REL_BP,
		OP_REL_NX, OP_REL_P, OP_ALLOC_START, OP_ALLOC_NEXT, OP_ALLOC_TEST,
		OP_ALLOC_SPLIT, OP_GROW, OP_FAIL, OP_PUBLISH
	} op_t;

	typedef struct packed {
		logic in_valid;
		logic in_free;
		logic free_ok;
		logic found;
		logic wlimit;
		logic over;
		logic fits;
		logic exact;
		logic at_rover;
		logic grow_ok;
		logic pub_ok;
	} status_t;

endpackage

// ===== rtl/core/ffa_ctrl.sv =====
// sequencer of the first-fit allocator: walks, merges, splits and growth
// depends on ffa_pkg and first_fit_free_list_allocator_macros.svh
`include "first_fit_free_list_allocator_macros.svh"

module ffa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  ffa_pkg::status_t st,
	output ffa_pkg::op_t     op,
	output logic             in_stall
);

	ffa_pkg::state_t state_q, state_d;
	logic from_grow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_IDLE;
			from_grow_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ffa_pkg::S_IDLE)
				from_grow_q <= 1'b0;
			else if (state_q == ffa_pkg::S_GROW && st.grow_ok)
				from_grow_q <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		op = ffa_pkg::OP_NONE;
		case (state_q)
			ffa_pkg::S_IDLE: begin
				if (st.in_valid) begin
					op = ffa_pkg::OP_LOAD;
					state_d = st.in_free ? ffa_pkg::S_FCHK : ffa_pkg::S_ASTART;
				end
			end
			ffa_pkg::S_FCHK: begin
				op = ffa_pkg::OP_FREE_CHK;
				state_d = st.free_ok ? ffa_pkg::S_RSTART : ffa_pkg::S_DONE;
			end
			ffa_pkg::S_RSTART: begin
				op = ffa_pkg::OP_REL_START;
				state_d = ffa_pkg::S_RTEST;
			end
			ffa_pkg::S_RTEST: begin
				op = ffa_pkg::OP_REL_TEST;
				if (st.found)
					state_d = ffa_pkg::S_RBP;
				else if (st.wlimit)
					state_d = from_grow_q ? ffa_pkg::S_AFAIL : ffa_pkg::S_DONE;
			end
			ffa_pkg::S_RBP: begin
				op = ffa_pkg::OP_REL_BP;
				state_d = ffa_pkg::S_RNX;
			end
			ffa_pkg::S_RNX: begin
				op = ffa_pkg::OP_REL_NX;
				state_d = ffa_pkg::S_RP;
			end
			ffa_pkg::S_RP: begin
				op = ffa_pkg::OP_REL_P;
				state_d = from_grow_q ? ffa_pkg::S_ASTART : ffa_pkg::S_DONE;
			end
			ffa_pkg::S_ASTART: begin
				op = ffa_pkg::OP_ALLOC_START;
				state_d = ffa_pkg::S_ANEXT;
			end
			ffa_pkg::S_ANEXT: begin
				op = ffa_pkg::OP_ALLOC_NEXT;
				state_d = ffa_pkg::S_ATEST;
			end
			ffa_pkg::S_ATEST: begin
				op = ffa_pkg::OP_ALLOC_TEST;
				if (st.over)
					state_d = ffa_pkg::S_AFAIL;
				else if (st.fits)
					state_d = st.exact ? ffa_pkg::S_DONE : ffa_pkg::S_ASPLIT;
				else if (st.at_rover)
					state_d = ffa_pkg::S_GROW;
			end
			ffa_pkg::S_ASPLIT: begin
				op = ffa_pkg::OP_ALLOC_SPLIT;
				state_d = ffa_pkg::S_DONE;
			end
			ffa_pkg::S_GROW: begin
				op = ffa_pkg::OP_GROW;
				state_d = st.grow_ok ? ffa_pkg::S_RSTART : ffa_pkg::S_AFAIL;
			end
			ffa_pkg::S_AFAIL: begin
				op = ffa_pkg::OP_FAIL;
				state_d = ffa_pkg::S_DONE;
			end
			ffa_pkg::S_DONE: begin
				if (st.pub_ok) begin
					op = ffa_pkg::OP_PUBLISH;
					state_d = ffa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffa_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ffa_pkg::S_IDLE);

	`FFA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, st.in_valid && !in_stall, state_q != ffa_pkg::S_IDLE, "request accepted but sequencer stayed idle")
	`FFA_ASSERT_NEXT(a_publish_returns_idle, clk, arst_n, op == ffa_pkg::OP_PUBLISH, state_q == ffa_pkg::S_IDLE, "result published without returning to idle")
	`FFA_ASSERT_NEXT(a_walk_bound_fails, clk, arst_n, state_q == ffa_pkg::S_ATEST && st.over, state_q == ffa_pkg::S_AFAIL, "walk bound reached but allocate did not fail")

endmodule

// ===== rtl/core/ffa_dp.sv =====
// datapath of the first-fit allocator: header memories, list pointers,
// config registers and result register; depends on ffa_pkg and the macros
`include "first_fit_free_list_allocator_macros.svh"

module ffa_dp #(
	parameter int MAX_UNITS  = 65536,
	parameter int GROW_MIN   = 1024,
	parameter int UNIT_BYTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffa_pkg::op_t                op,
	output ffa_pkg::status_t            st,
	input  logic                        in_valid,
	input  logic                        req_type,
	input  logic [ffa_pkg::BYTES_W-1:0] alloc_bytes,
	input  logic [ffa_pkg::ADDR_W-1:0]  free_addr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [ffa_pkg::ADDR_W-1:0]  result_addr,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffa_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [ffa_pkg::ADDR_W-1:0]  cfg_data
);

	// unit sizes are powers of two
	localparam int SH = $clog2(UNIT_BYTES);
	localparam int NW = $clog2(MAX_UNITS + 1);
	localparam int AW = $clog2(MAX_UNITS);
	localparam int KW = ffa_pkg::BYTES_W - SH + 1;
	localparam int WALK_LIMIT = 2 * MAX_UNITS + 8;
	localparam int CW = $clog2(WALK_LIMIT + 2);

	logic [NW-1:0] next_mem [MAX_UNITS];
	logic [NW-1:0] size_mem [MAX_UNITS];

	// config
	logic                       heap_active_q;
	logic [ffa_pkg::HU_W-1:0]   heap_units_q;
	logic [ffa_pkg::ADDR_W-1:0] arena_base_q;

	// list state
	logic [NW-1:0] sentinel_q, rover_q, break_q;
	logic          started_q;

	// request and walk registers
	logic                        req_q;
	logic [ffa_pkg::BYTES_W-1:0] bytes_q;
	logic [ffa_pkg::ADDR_W-1:0]  faddr_q;
	logic [NW-1:0] p_q, prev_q, nx_q, bp_q, szp_q, szbp_q, nbsz_q, nbnext_q;
	logic [CW-1:0] steps_q, wsteps_q;
	logic                        res_status_q, out_status_q, out_valid_q;
	logic [ffa_pkg::ADDR_W-1:0]  res_addr_q, out_addr_q;

	// memory ports
	logic          rd_en;
	logic [NW-1:0] rd_node, rd_node_q, next_rd_q, size_rd_q;
	logic [NW-1:0] wr_node, wsz, wnx;
	logic          wsz_en, wnx_en;
	logic [NW-1:0] view_next, view_size;

	logic [KW-1:0]              need;
	logic [ffa_pkg::ADDR_W-1:0] off, node32, limit32, nu32, brk32;
	logic [NW:0]                hi_sum, lo_sum;
	logic                       hi_merge, lo_merge, rd_rng, wr_rng;

	function automatic logic [ffa_pkg::ADDR_W-1:0] node_addr(
		input logic [ffa_pkg::ADDR_W-1:0] base, input logic [NW-1:0] n);
		node_addr = base + (ffa_pkg::ADDR_W'(n) << SH);
	endfunction

	assign need = KW'(((KW + SH)'(bytes_q) + (KW + SH)'(UNIT_BYTES - 1)) >> SH) + KW'(1);

	// a node outside 1..MAX reads as size 0; node 0 reads next sentinel_q, a node above MAX next 0
	assign rd_rng = (rd_node_q != '0) && (rd_node_q <= NW'(MAX_UNITS));
	assign view_next = (rd_node_q == '0) ? sentinel_q : (rd_rng ? next_rd_q : '0);
	assign view_size = rd_rng ? size_rd_q : '0;

	assign off = faddr_q - arena_base_q;
	assign node32 = off >> SH;
	assign brk32 = ffa_pkg::ADDR_W'(break_q);
	assign limit32 = (ffa_pkg::ADDR_W'(heap_units_q) < ffa_pkg::ADDR_W'(MAX_UNITS)) ?
		ffa_pkg::ADDR_W'(heap_units_q) : ffa_pkg::ADDR_W'(MAX_UNITS);
	assign nu32 = (ffa_pkg::ADDR_W'(need) < ffa_pkg::ADDR_W'(GROW_MIN)) ?
		ffa_pkg::ADDR_W'(GROW_MIN) : ffa_pkg::ADDR_W'(need);

	assign hi_sum = {1'b0, bp_q} + {1'b0, szbp_q};
	assign hi_merge = (hi_sum == {1'b0, nx_q});
	assign lo_sum = {1'b0, p_q} + {1'b0, szp_q};
	assign lo_merge = (lo_sum == {1'b0, bp_q});

	always_comb begin
		st = '0;
		st.in_valid = in_valid;
		st.in_free = (req_type == ffa_pkg::REQ_FREE);
		st.free_ok = (faddr_q >= arena_base_q) && (off[SH-1:0] == '0) &&
			(node32 != '0) && (node32 <= brk32);
		st.found = ((bp_q > p_q) && (bp_q < view_next)) ||
			((p_q >= view_next) && ((bp_q > p_q) || (bp_q < view_next)));
		st.wlimit = !st.found && (wsteps_q >= CW'(WALK_LIMIT));
		st.over = (steps_q >= CW'(WALK_LIMIT));
		st.fits = (ffa_pkg::ADDR_W'(view_size) >= ffa_pkg::ADDR_W'(need));
		st.exact = (ffa_pkg::ADDR_W'(view_size) == ffa_pkg::ADDR_W'(need));
		st.at_rover = (p_q == rover_q);
		st.grow_ok = heap_active_q && !(brk32 > limit32) && !(nu32 > (limit32 - brk32));
		st.pub_ok = !out_valid_q || !out_stall;
	end

	// memory read and write addresses by command
	always_comb begin
		rd_en = 1'b0;
		rd_node = '0;
		wr_node = '0;
		wsz_en = 1'b0;
		wsz = '0;
		wnx_en = 1'b0;
		wnx = '0;
		case (op)
			ffa_pkg::OP_REL_START, ffa_pkg::OP_ALLOC_START: begin
				rd_en = 1'b1;
				rd_node = rover_q;
			end
			ffa_pkg::OP_ALLOC_NEXT: begin
				rd_en = 1'b1;
				rd_node = view_next;
			end
			ffa_pkg::OP_REL_TEST: begin
				rd_en = 1'b1;
				rd_node = st.found ? bp_q : view_next;
			end
			ffa_pkg::OP_REL_BP: begin
				rd_en = 1'b1;
				rd_node = nx_q;
			end
			ffa_pkg::OP_REL_NX: begin
				wr_node = bp_q;
				wnx_en = 1'b1;
				if (hi_merge) begin
					wsz_en = 1'b1;
					wsz = szbp_q + view_size;
					wnx = view_next;
				end else begin
					wnx = nx_q;
				end
			end
			ffa_pkg::OP_REL_P: begin
				wr_node = p_q;
				wnx_en = 1'b1;
				if (lo_merge) begin
					wsz_en = 1'b1;
					wsz = szp_q + nbsz_q;
					wnx = nbnext_q;
				end else begin
					wnx = bp_q;
				end
			end
			ffa_pkg::OP_ALLOC_TEST: begin
				if (!st.over && st.fits) begin
					if (st.exact) begin
						wr_node = prev_q;
						wnx_en = 1'b1;
						wnx = view_next;
					end else begin
						wr_node = p_q;
						wsz_en = 1'b1;
						wsz = NW'(ffa_pkg::ADDR_W'(view_size) - ffa_pkg::ADDR_W'(need));
					end
				end else if (!st.over && !st.at_rover) begin
					rd_en = 1'b1;
					rd_node = view_next;
				end
			end
			ffa_pkg::OP_ALLOC_SPLIT: begin
				wr_node = p_q;
				wsz_en = 1'b1;
				wsz = NW'(need);
			end
			ffa_pkg::OP_GROW: begin
				wr_node = break_q + NW'(1);
				wsz_en = st.grow_ok;
				wsz = NW'(nu32);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign wr_rng = (wr_node != '0) && (wr_node <= NW'(MAX_UNITS));

	always_ff @(posedge clk) begin
		if (rd_en) begin
			next_rd_q <= next_mem[AW'(rd_node - NW'(1))];
			size_rd_q <= size_mem[AW'(rd_node - NW'(1))];
			rd_node_q <= rd_node;
		end
		if (wnx_en && wr_rng)
			next_mem[AW'(wr_node - NW'(1))] <= wnx;
		if (wsz_en && wr_rng)
			size_mem[AW'(wr_node - NW'(1))] <= wsz;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_active_q <= 1'b0;
			heap_units_q <= '0;
			arena_base_q <= '0;
			sentinel_q <= '0;
			rover_q <= '0;
			break_q <= '0;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ffa_pkg::CFG_HEAP_ACTIVE: heap_active_q <= cfg_data[0];
					ffa_pkg::CFG_HEAP_UNITS:  heap_units_q <= cfg_data[ffa_pkg::HU_W-1:0];
					ffa_pkg::CFG_ARENA_BASE:  arena_base_q <= cfg_data;
					default: heap_active_q <= heap_active_q;
				endcase
			end
			if (wnx_en && wr_node == '0)
				sentinel_q <= wnx;
			case (op)
				ffa_pkg::OP_LOAD: begin
					if (!started_q) begin
						sentinel_q <= '0;
						rover_q <= '0;
						started_q <= 1'b1;
					end
				end
				ffa_pkg::OP_REL_P: rover_q <= p_q;
				ffa_pkg::OP_ALLOC_TEST: begin
					if (!st.over && st.fits && st.exact)
						rover_q <= prev_q;
				end
				ffa_pkg::OP_ALLOC_SPLIT: rover_q <= prev_q;
				ffa_pkg::OP_GROW: begin
					if (st.grow_ok)
						break_q <= NW'(brk32 + nu32);
				end
				default: rover_q <= rover_q;
			endcase
			if (op == ffa_pkg::OP_PUBLISH)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		case (op)
			ffa_pkg::OP_LOAD: begin
				req_q <= req_type;
				bytes_q <= alloc_bytes;
				faddr_q <= free_addr;
				steps_q <= '0;
				res_status_q <= 1'b0;
				res_addr_q <= '0;
			end
			ffa_pkg::OP_FREE_CHK: bp_q <= NW'(node32);
			ffa_pkg::OP_REL_START: begin
				p_q <= rover_q;
				wsteps_q <= '0;
			end
			ffa_pkg::OP_REL_TEST: begin
				if (st.found) begin
					nx_q <= view_next;
					szp_q <= view_size;
				end else if (!st.wlimit) begin
					wsteps_q <= wsteps_q + CW'(1);
					p_q <= view_next;
				end
			end
			ffa_pkg::OP_REL_BP: szbp_q <= view_size;
			ffa_pkg::OP_REL_NX: begin
				nbsz_q <= hi_merge ? szbp_q + view_size : szbp_q;
				nbnext_q <= hi_merge ? view_next : nx_q;
			end
			ffa_pkg::OP_ALLOC_START: prev_q <= rover_q;
			ffa_pkg::OP_ALLOC_NEXT: p_q <= view_next;
			ffa_pkg::OP_ALLOC_TEST: begin
				steps_q <= steps_q + CW'(1);
				if (!st.over && st.fits) begin
					if (st.exact)
						res_addr_q <= node_addr(arena_base_q, p_q);
					else
						p_q <= p_q + NW'(ffa_pkg::ADDR_W'(view_size) - ffa_pkg::ADDR_W'(need));
				end else if (!st.over && !st.at_rover) begin
					prev_q <= p_q;
					p_q <= view_next;
				end
			end
			ffa_pkg::OP_ALLOC_SPLIT: res_addr_q <= node_addr(arena_base_q, p_q);
			ffa_pkg::OP_GROW: bp_q <= break_q + NW'(1);
			ffa_pkg::OP_FAIL: begin
				res_status_q <= 1'b1;
				res_addr_q <= '0;
			end
			ffa_pkg::OP_PUBLISH: begin
				// a free always answers done with address zero
				out_status_q <= (req_q == ffa_pkg::REQ_FREE) ? 1'b0 : res_status_q;
				out_addr_q <= (req_q == ffa_pkg::REQ_FREE) ? '0 : res_addr_q;
			end
			default: steps_q <= steps_q;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign result_addr = out_addr_q;

	`FFA_ASSERT(a_break_in_range, clk, arst_n, break_q <= NW'(MAX_UNITS), "break beyond arena")
	`FFA_ASSERT(a_place_not_self, clk, arst_n, (op == ffa_pkg::OP_REL_TEST && st.found) |-> (view_next != bp_q && p_q != bp_q), "released block found next to itself")
	`FFA_ASSERT(a_no_overwrite, clk, arst_n, (op == ffa_pkg::OP_PUBLISH) |-> (!out_valid_q || !out_stall), "result overwrites one not yet taken")

endmodule

// ===== rtl/core/first_fit_free_list_allocator.sv =====
// top level of the first-fit free-list allocator
// depends on ffa_pkg, ffa_ctrl and ffa_dp
//
// Allocates and frees blocks of an arena of UNIT_BYTES-byte units kept as an
// address-ordered circular free list with a next-fit rover; every request
// gives one result. One request is in work at a time, and a new one is
// taken while the previous result still waits on the output. The list
// walk reads one header a cycle from the header memories, so the time
// taken grows with the free blocks visited. An allocate runs start, next
// and a test per block, plus a split if needed; a free runs check, start, a
// test per block and the bp, nx and p merges. Growth adds a free walk and a
// new allocate walk. No clearing pass is needed after reset.
module first_fit_free_list_allocator #(
	parameter int MAX_UNITS  = 65536,
	parameter int GROW_MIN   = 1024,
	parameter int UNIT_BYTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [ffa_pkg::BYTES_W-1:0] alloc_bytes,
	input  logic [ffa_pkg::ADDR_W-1:0]  free_addr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [ffa_pkg::ADDR_W-1:0]  result_addr,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffa_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [ffa_pkg::ADDR_W-1:0]  cfg_data
);

	ffa_pkg::op_t     op;
	ffa_pkg::status_t st;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.st       (st),
		.op       (op),
		.in_stall (in_stall)
	);

	ffa_dp #(
		.MAX_UNITS  (MAX_UNITS),
		.GROW_MIN   (GROW_MIN),
		.UNIT_BYTES (UNIT_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.st          (st),
		.in_valid    (in_valid),
		.req_type    (req_type),
		.alloc_bytes (alloc_bytes),
		.free_addr   (free_addr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.result_addr (result_addr),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

endmodule
